FILE: rtl/coxeter_fundamental_domain_fold_assert.svh
// ----------------------------------------------------------------------------
// Fold assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef COXETER_FUNDAMENTAL_DOMAIN_FOLD_ASSERT_SVH
`define COXETER_FUNDAMENTAL_DOMAIN_FOLD_ASSERT_SVH

// same-cycle implication
`define CFDF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fold assertion failed");

// next-cycle implication
`define CFDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fold assertion failed");

`endif

FILE: rtl/cfdf_pkg.sv
// ----------------------------------------------------------------------------
// Fold package
// Widths, constants, state and register codes, rounding helpers.
// ----------------------------------------------------------------------------
package cfdf_pkg;

  localparam int FB       = 16;
  localparam int MAX_ITER = 500;
  localparam int PASS_W   = $clog2(MAX_ITER + 1);
  localparam int IN_W     = 18;
  localparam int CFG_W    = 24;
  localparam int RAD_W    = 23;
  localparam int PT_W     = 32;
  localparam int CNT_W    = 11;
  localparam int SCALE_W  = 32;
  localparam int DIST_W   = 24;
  localparam int PROD_W   = 66;
  localparam int ACC_W    = 68;
  localparam int ADDR_W   = 5;

  localparam logic signed [PT_W-1:0] PT_LIM    = {1'b0, {(PT_W-1){1'b1}}};
  localparam logic [SCALE_W-1:0]     FAC_CAP   = '1;
  localparam logic [CNT_W-1:0]       CNT_MAX   = '1;
  localparam logic [DIST_W-1:0]      DIST_MAX  = '1;

  typedef enum logic [2:0] {
    REG_BY  = 3'd0,
    REG_BZ  = 3'd1,
    REG_SX  = 3'd2,
    REG_SY  = 3'd3,
    REG_SZ  = 3'd4,
    REG_RAD = 3'd5
  } reg_idx_e;

  typedef enum logic [5:0] {
    S_IDLE, S_A,
    S_B1, S_B2, S_B3, S_B4, S_B5, S_B6,
    S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_CDIV, S_C8, S_C9, S_C10, S_C11, S_C12,
    S_D, S_R1, S_R2, S_R3, S_R4, S_SQRT, S_RNSET, S_RNDIV, S_RNPUT, S_CHK,
    S_L1, S_L2, S_L3, S_L4, S_L5, S_L6, S_L7, S_L8, S_L10, S_OUT
  } state_e;

  function automatic logic signed [ACC_W-1:0] rnd_shr(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] m;
    m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    m = (m + (ACC_W'(1) << (FB - 1))) >> FB;
    return v[ACC_W-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [PT_W-1:0] sat_pt(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] lim;
    lim = ACC_W'(PT_LIM);
    if (v > lim) begin
      return PT_LIM;
    end else if (v < -lim) begin
      return -PT_LIM;
    end
    return v[PT_W-1:0];
  endfunction

endpackage

FILE: rtl/cfdf_in_if.sv
// ----------------------------------------------------------------------------
// Fold channel interfaces
// Point input channel and result output channel, valid/ready.
// ----------------------------------------------------------------------------
interface cfdf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [cfdf_pkg::IN_W-1:0]    point_x;
  logic signed [cfdf_pkg::IN_W-1:0]    point_y;
  logic signed [cfdf_pkg::IN_W-1:0]    point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface cfdf_out_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic [cfdf_pkg::CNT_W-1:0]          reflection_count;
  logic [cfdf_pkg::SCALE_W-1:0]        orbit_scale;
  logic signed [cfdf_pkg::IN_W-1:0]    folded_x;
  logic signed [cfdf_pkg::IN_W-1:0]    folded_y;
  logic signed [cfdf_pkg::IN_W-1:0]    folded_z;
  logic [cfdf_pkg::DIST_W-1:0]         mirror_distance;

  modport source (output valid, found, reflection_count, orbit_scale, folded_x, folded_y,
                  folded_z, mirror_distance, input ready);
  modport sink   (input valid, found, reflection_count, orbit_scale, folded_x, folded_y,
                  folded_z, mirror_distance, output ready);
endinterface

FILE: rtl/coxeter_fundamental_domain_fold.sv
// ----------------------------------------------------------------------------
// Coxeter fundamental domain fold
// Folds a unit-sphere point into the cell of a rank-4 Coxeter group using one
// shared multiplier and one shared shift-subtract unit under a sequencer.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | content
//  in_i     | in  | valid/ready         | point_x, point_y, point_z
//  out_o    | out | valid/ready         | found, count, scale, folded point, distance
//  apb      | in  | psel/penable/pwrite | six mirror and sphere registers
//
//  Each item is accepted, folded in up to 500 passes, then given its distance
//  and handed off; the 32-step square root, the 32-step inversion divide and
//  the 17-step renormalising divides run on the shift-subtract unit.
//  Reset clears the sequencer and loads the register defaults.
//  A result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`include "coxeter_fundamental_domain_fold_assert.svh"

module coxeter_fundamental_domain_fold (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cfdf_in_if.sink                      in_i,
  cfdf_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cfdf_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import cfdf_pkg::*;

  state_e state_q, state_d;

  logic signed [CFG_W-1:0] by_q, bz_q, sx_q, sy_q, sz_q;
  logic [RAD_W-1:0]        rad_q;

  logic signed [PT_W-1:0]   px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d, cnt_inc;
  logic [SCALE_W-1:0]       scale_q, scale_d;
  logic [PASS_W-1:0]        pass_q, pass_d;
  logic                     ok_q, ok_d, found_q, found_d, ld_q, ld_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [32:0]       dx_q, dx_d, dy_q, dy_d, dz_q, dz_d, fac_q, fac_d;
  logic [2*RAD_W-1:0]       rr_q, rr_d;
  logic [47:0]              rem_q, rem_d, div_q, div_d;
  logic [63:0]              num_q, num_d;
  logic [31:0]              quo_q, quo_d, len_q, len_d;
  logic [5:0]               it_q, it_d;
  logic [1:0]               comp_q, comp_d;
  logic [41:0]              best_q, best_d;

  logic                     out_valid_q, out_valid_d;
  logic                     o_found_q;
  logic [CNT_W-1:0]         o_cnt_q;
  logic [SCALE_W-1:0]       o_scale_q;
  logic signed [IN_W-1:0]   o_x_q, o_y_q, o_z_q;
  logic [DIST_W-1:0]        o_dist_q;
  logic                     out_load;

  logic signed [32:0]       mul_a, mul_b;
  logic signed [ACC_W-1:0]  prod_x, sum_x, rnd_sum, rnd_p, rnd_p2, fac_b;
  logic [63:0]              dd_u, sc_p;
  logic [49:0]              st_t, st_s, st_dif;
  logic                     st_ge, st_last;
  logic signed [PT_W-1:0]   pc;
  logic [31:0]              mag_c, amx, amz, rad_x, cand_c;
  logic [47:0]              rn_num;
  logic [41:0]              db, m1;

  // configuration port
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      by_q  <= 24'sd56756;
      bz_q  <= -24'sd32768;
      sx_q  <= 24'sd155026;
      sy_q  <= 24'sd99340;
      sz_q  <= '0;
      rad_q <= 23'd172066;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_BY:  by_q  <= pwdata[CFG_W-1:0];
        REG_BZ:  bz_q  <= pwdata[CFG_W-1:0];
        REG_SX:  sx_q  <= pwdata[CFG_W-1:0];
        REG_SY:  sy_q  <= pwdata[CFG_W-1:0];
        REG_SZ:  sz_q  <= pwdata[CFG_W-1:0];
        REG_RAD: rad_q <= pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      REG_BY:  prdata = 32'(by_q);
      REG_BZ:  prdata = 32'(bz_q);
      REG_SX:  prdata = 32'(sx_q);
      REG_SY:  prdata = 32'(sy_q);
      REG_SZ:  prdata = 32'(sz_q);
      REG_RAD: prdata = 32'(rad_q);
      default: prdata = '0;
    endcase
  end

  // shared arithmetic
  assign prod_d  = mul_a * mul_b;
  assign prod_x  = ACC_W'(prod_q);
  assign sum_x   = acc_q + prod_x;
  assign rnd_sum = rnd_shr(sum_x);
  assign rnd_p   = rnd_shr(prod_x);
  assign rnd_p2  = rnd_shr(prod_x <<< 1);
  assign fac_b   = (rnd_sum < -ACC_W'(PT_LIM)) ? -ACC_W'(PT_LIM) : rnd_sum;
  assign dd_u    = sum_x[63:0];
  assign sc_p    = prod_q[63:0] + (64'd1 << (FB - 1));
  assign cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + CNT_W'(1);

  assign st_t    = (state_q == S_SQRT) ? {rem_q, num_q[63:62]} : {1'b0, rem_q, num_q[63]};
  assign st_s    = (state_q == S_SQRT) ? 50'({quo_q, 2'b01}) : 50'(div_q);
  assign st_ge   = st_t >= st_s;
  assign st_dif  = st_t - st_s;
  assign st_last = (it_q == 6'd1);

  always_comb begin
    case (comp_q)
      2'd0:    pc = px_q;
      2'd1:    pc = py_q;
      default: pc = pz_q;
    endcase
  end
  assign mag_c  = pc[PT_W-1] ? 32'(-pc) : 32'(pc);
  assign rn_num = {mag_c[31:0], 16'b0} + 48'(len_q >> 1);
  assign amx    = px_q[PT_W-1] ? 32'(-px_q) : 32'(px_q);
  assign amz    = pz_q[PT_W-1] ? 32'(-pz_q) : 32'(pz_q);
  assign db     = rnd_sum[ACC_W-1] ? 42'(-rnd_sum) : 42'(rnd_sum);
  assign m1     = (amx < amz) ? 42'(amx) : 42'(amz);
  assign rad_x  = 32'(rad_q);
  assign cand_c = (len_q >= rad_x) ? len_q - rad_x : rad_x - len_q;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_i.valid) state_d = S_A;
      S_A:     state_d = S_B1;
      S_B1:    state_d = S_B2;
      S_B2:    state_d = S_B3;
      S_B3:    state_d = sum_x[ACC_W-1] ? S_B4 : S_C1;
      S_B4:    state_d = S_B5;
      S_B5:    state_d = S_B6;
      S_B6:    state_d = S_C1;
      S_C1:    state_d = S_C2;
      S_C2:    state_d = S_C3;
      S_C3:    state_d = S_C4;
      S_C4:    state_d = S_C5;
      S_C5:    state_d = S_C6;
      S_C6: begin
        if (dd_u == '0 || 64'(rr_q) < dd_u) begin
          state_d = S_D;
        end else if (64'(rr_q) >= (dd_u << FB)) begin
          state_d = S_C8;
        end else begin
          state_d = S_CDIV;
        end
      end
      S_CDIV:  if (st_last) state_d = S_C8;
      S_C8:    state_d = S_C9;
      S_C9:    state_d = S_C10;
      S_C10:   state_d = S_C11;
      S_C11:   state_d = S_C12;
      S_C12:   state_d = S_D;
      S_D:     state_d = S_R1;
      S_R1:    state_d = S_R2;
      S_R2:    state_d = S_R3;
      S_R3:    state_d = S_R4;
      S_R4:    state_d = S_SQRT;
      S_SQRT: begin
        if (st_last) begin
          if (ld_q) begin
            state_d = S_L10;
          end else if (quo_d == '0) begin
            state_d = S_CHK;
          end else begin
            state_d = S_RNSET;
          end
        end
      end
      S_RNSET: state_d = S_RNDIV;
      S_RNDIV: if (st_last) state_d = S_RNPUT;
      S_RNPUT: state_d = (comp_q == 2'd2) ? S_CHK : S_RNSET;
      S_CHK: begin
        if (ok_q || (pass_q + PASS_W'(1) == PASS_W'(MAX_ITER))) begin
          state_d = S_L1;
        end else begin
          state_d = S_A;
        end
      end
      S_L1:    state_d = S_L2;
      S_L2:    state_d = S_L3;
      S_L3:    state_d = S_L4;
      S_L4:    state_d = S_L5;
      S_L5:    state_d = S_L6;
      S_L6:    state_d = S_L7;
      S_L7:    state_d = S_L8;
      S_L8:    state_d = S_SQRT;
      S_L10:   state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    px_d = px_q;  py_d = py_q;  pz_d = pz_q;
    cnt_d = cnt_q;  scale_d = scale_q;  pass_d = pass_q;
    ok_d = ok_q;  found_d = found_q;  ld_d = ld_q;
    acc_d = acc_q;  dx_d = dx_q;  dy_d = dy_q;  dz_d = dz_q;  fac_d = fac_q;
    rr_d = rr_q;  rem_d = rem_q;  div_d = div_q;  num_d = num_q;  quo_d = quo_q;
    it_d = it_q;  comp_d = comp_q;  len_d = len_q;  best_d = best_q;
    mul_a = '0;  mul_b = '0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          px_d = PT_W'(in_i.point_x);
          py_d = PT_W'(in_i.point_y);
          pz_d = PT_W'(in_i.point_z);
          cnt_d = '0;
          scale_d = SCALE_W'(1) << FB;
          pass_d = '0;
        end
      end
      S_A: begin
        ok_d = 1'b1;
        if (pz_q[PT_W-1]) begin
          pz_d = -pz_q;  cnt_d = cnt_inc;  ok_d = 1'b0;
        end
      end
      S_B1: begin
        mul_a = 33'(py_q);  mul_b = 33'(by_q);
      end
      S_B2: begin
        acc_d = prod_x;  mul_a = 33'(pz_q);  mul_b = 33'(bz_q);
      end
      S_B3:  fac_d = fac_b[32:0];
      S_B4: begin
        mul_a = fac_q;  mul_b = 33'(by_q);
      end
      S_B5: begin
        py_d = sat_pt(ACC_W'(py_q) - rnd_p2);
        mul_a = fac_q;  mul_b = 33'(bz_q);
      end
      S_B6: begin
        pz_d = sat_pt(ACC_W'(pz_q) - rnd_p2);
        cnt_d = cnt_inc;  ok_d = 1'b0;
      end
      S_C1, S_L4: begin
        dx_d = 33'(px_q) - 33'(sx_q);
        dy_d = 33'(py_q) - 33'(sy_q);
        dz_d = 33'(pz_q) - 33'(sz_q);
      end
      S_C2: begin
        mul_a = 33'(rad_q);  mul_b = 33'(rad_q);
      end
      S_C3: begin
        rr_d = prod_q[2*RAD_W-1:0];  mul_a = dx_q;  mul_b = dx_q;
      end
      S_C4, S_L6: begin
        acc_d = prod_x;  mul_a = dy_q;  mul_b = dy_q;
      end
      S_C5, S_L7: begin
        acc_d = sum_x;  mul_a = dz_q;  mul_b = dz_q;
      end
      S_C6: begin
        fac_d = {1'b0, FAC_CAP};
        rem_d = 48'(rr_q >> FB);
        num_d = {rr_q[FB-1:0], 48'b0};
        div_d = dd_u[47:0];
        quo_d = '0;
        it_d  = 6'd32;
      end
      S_CDIV, S_RNDIV, S_SQRT: begin
        rem_d = st_ge ? st_dif[47:0] : st_t[47:0];
        num_d = (state_q == S_SQRT) ? num_q << 2 : num_q << 1;
        quo_d = {quo_q[30:0], st_ge};
        it_d  = it_q - 6'd1;
        if (state_q == S_CDIV) fac_d = {1'b0, quo_d};
        if (state_q == S_SQRT) len_d = quo_d;
      end
      S_C8: begin
        mul_a = fac_q;  mul_b = dx_q;
      end
      S_C9: begin
        px_d = sat_pt(rnd_p + ACC_W'(sx_q));  mul_a = fac_q;  mul_b = dy_q;
      end
      S_C10: begin
        py_d = sat_pt(rnd_p + ACC_W'(sy_q));  mul_a = fac_q;  mul_b = dz_q;
      end
      S_C11: begin
        pz_d = sat_pt(rnd_p + ACC_W'(sz_q));  mul_a = fac_q;  mul_b = {1'b0, scale_q};
      end
      S_C12: begin
        scale_d = (|sc_p[63:48]) ? FAC_CAP : sc_p[47:16];
        cnt_d = cnt_inc;  ok_d = 1'b0;
      end
      S_D: begin
        if (px_q[PT_W-1]) begin
          px_d = -px_q;  cnt_d = cnt_inc;  ok_d = 1'b0;
        end
      end
      S_R1: begin
        mul_a = 33'(px_q);  mul_b = 33'(px_q);
      end
      S_R2: begin
        acc_d = prod_x;  mul_a = 33'(py_q);  mul_b = 33'(py_q);
      end
      S_R3: begin
        acc_d = sum_x;  mul_a = 33'(pz_q);  mul_b = 33'(pz_q);
      end
      S_R4, S_L8: begin
        num_d = dd_u;  rem_d = '0;  quo_d = '0;  it_d = 6'd32;
        ld_d = (state_q == S_L8);  comp_d = '0;
      end
      S_RNSET: begin
        rem_d = 48'(rn_num >> 17);
        num_d = {rn_num[16:0], 47'b0};
        div_d = 48'(len_q);
        quo_d = '0;
        it_d  = 6'd17;
      end
      S_RNPUT: begin
        case (comp_q)
          2'd0:    px_d = pc[PT_W-1] ? -$signed(quo_q) : $signed(quo_q);
          2'd1:    py_d = pc[PT_W-1] ? -$signed(quo_q) : $signed(quo_q);
          default: pz_d = pc[PT_W-1] ? -$signed(quo_q) : $signed(quo_q);
        endcase
        comp_d = comp_q + 2'd1;
      end
      S_CHK: begin
        found_d = ok_q;
        if (!(ok_q || (pass_q + PASS_W'(1) == PASS_W'(MAX_ITER)))) begin
          pass_d = pass_q + PASS_W'(1);
        end
      end
      S_L1: begin
        mul_a = 33'(py_q);  mul_b = 33'(by_q);
      end
      S_L2: begin
        acc_d = prod_x;  mul_a = 33'(pz_q);  mul_b = 33'(bz_q);
      end
      S_L3:  best_d = (db < m1) ? db : m1;
      S_L5: begin
        mul_a = dx_q;  mul_b = dx_q;
      end
      S_L10: if (42'(cand_c) < best_q) best_d = 42'(cand_c);
      default: ;
    endcase
  end

  // handshake
  always_comb begin
    in_i.ready  = (state_q == S_IDLE);
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pass_q      <= '0;
      it_q        <= '0;
      comp_q      <= '0;
      ld_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pass_q      <= pass_d;
      it_q        <= it_d;
      comp_q      <= comp_d;
      ld_q        <= ld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;  py_q <= py_d;  pz_q <= pz_d;
    cnt_q <= cnt_d;  scale_q <= scale_d;  ok_q <= ok_d;  found_q <= found_d;
    acc_q <= acc_d;  prod_q <= prod_d;
    dx_q <= dx_d;  dy_q <= dy_d;  dz_q <= dz_d;  fac_q <= fac_d;  rr_q <= rr_d;
    rem_q <= rem_d;  div_q <= div_d;  num_q <= num_d;  quo_q <= quo_d;
    len_q <= len_d;  best_q <= best_d;
    if (out_load) begin
      o_found_q <= found_q;
      o_cnt_q   <= cnt_q;
      o_scale_q <= scale_q;
      o_x_q     <= px_q[IN_W-1:0];
      o_y_q     <= py_q[IN_W-1:0];
      o_z_q     <= pz_q[IN_W-1:0];
      o_dist_q  <= (|best_q[41:DIST_W]) ? DIST_MAX : best_q[DIST_W-1:0];
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.found            = o_found_q;
  assign out_o.reflection_count = o_cnt_q;
  assign out_o.orbit_scale      = o_scale_q;
  assign out_o.folded_x         = o_x_q;
  assign out_o.folded_y         = o_y_q;
  assign out_o.folded_z         = o_z_q;
  assign out_o.mirror_distance  = o_dist_q;

  `CFDF_ASSERT_NEXT(a_start, in_i.valid && in_i.ready, state_q == S_A)
  `CFDF_ASSERT_IMP(a_pass_bound, 1'b1, pass_q < PASS_W'(MAX_ITER))
  `CFDF_ASSERT_IMP(a_iter_live, state_q == S_SQRT || state_q == S_CDIV || state_q == S_RNDIV, it_q != 6'd0)
  `CFDF_ASSERT_NEXT(a_result_load, out_load, out_valid_q && state_q == S_IDLE)

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Fold testbench
// Drives unit-sphere points and noise through the fold block under several
// mirror and sphere settings, predicts each result in a scoreboard and checks
// every returned item field by field. Sender bursts, receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import cfdf_pkg::*;

  typedef struct packed {
    logic        found;
    logic [10:0] count;
    logic [31:0] scale;
    logic [17:0] fx;
    logic [17:0] fy;
    logic [17:0] fz;
    logic [23:0] mdist;
  } fold_res_t;

  class fold_scoreboard;
    longint    by, bz, sx, sy, sz, rad;
    fold_res_t expected_q[$];
    int        errors;

    function new();
      by = 56756; bz = -32768; sx = 155026; sy = 99340; sz = 0; rad = 172066;
      errors = 0;
    endfunction

    function longint sext(longint unsigned v, int w);
      longint unsigned m;
      m = (64'd1 << w) - 1;
      v = v & m;
      if (v >> (w - 1)) return longint'(v) - longint'(m + 1);
      return longint'(v);
    endfunction

    function void set_reg(reg_idx_e idx, longint unsigned v);
      case (idx)
        REG_BY:  by  = sext(v, 24);
        REG_BZ:  bz  = sext(v, 24);
        REG_SX:  sx  = sext(v, 24);
        REG_SY:  sy  = sext(v, 24);
        REG_SZ:  sz  = sext(v, 24);
        REG_RAD: rad = longint'(v & 64'h7F_FFFF);
        default: ;
      endcase
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(0) - v : v;
    endfunction

    function longint rnd16(longint v);
      longint unsigned m;
      m = (mag(v) + 64'd32768) >> 16;
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483647) return -64'sd2147483647;
      return v;
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v = v - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function longint unsigned centre_d2(longint p[3], output longint d[3]);
      d[0] = p[0] - sx;
      d[1] = p[1] - sy;
      d[2] = p[2] - sz;
      return mag(d[0]) * mag(d[0]) + mag(d[1]) * mag(d[1]) + mag(d[2]) * mag(d[2]);
    endfunction

    function fold_res_t fold(logic [17:0] x, logic [17:0] y, logic [17:0] z);
      fold_res_t r;
      longint p[3], d[3], dotv, f;
      longint unsigned cnt, scale, dd, rr, q, rem, prod, acc, len, m, best, cand, root;
      bit done, ok;
      int pass;
      p[0] = sext(x, 18); p[1] = sext(y, 18); p[2] = sext(z, 18);
      cnt = 0; scale = 64'd65536; done = 0;
      for (pass = 0; pass < 500 && !done; pass++) begin
        ok = 1;
        if (p[2] < 0) begin
          p[2] = -p[2]; cnt++; ok = 0;
        end
        dotv = p[1] * by + p[2] * bz;
        if (dotv < 0) begin
          f = rnd16(dotv);
          if (f < -64'sd2147483647) f = -64'sd2147483647;
          p[1] = sat(p[1] - rnd16(2 * f * by));
          p[2] = sat(p[2] - rnd16(2 * f * bz));
          cnt++; ok = 0;
        end
        dd = centre_d2(p, d);
        rr = longint'(rad) * longint'(rad);
        if (dd != 0 && rr >= dd) begin
          q = rr / dd;
          rem = rr % dd;
          if (q > 64'hFFFF_FFFF) begin
            q = 64'hFFFF_FFFF;
          end else begin
            for (int b = 0; b < 16; b++) begin
              rem = rem << 1;
              q = q << 1;
              if (rem >= dd) begin
                rem = rem - dd; q = q | 1;
              end
              if (q > 64'hFFFF_FFFF) begin
                q = 64'hFFFF_FFFF;
                break;
              end
            end
          end
          p[0] = sat(rnd16(longint'(q) * d[0]) + sx);
          p[1] = sat(rnd16(longint'(q) * d[1]) + sy);
          p[2] = sat(rnd16(longint'(q) * d[2]) + sz);
          prod = (scale * q + 64'd32768) >> 16;
          scale = prod > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : prod;
          cnt++; ok = 0;
        end
        if (p[0] < 0) begin
          p[0] = -p[0]; cnt++; ok = 0;
        end
        acc = mag(p[0]) * mag(p[0]) + mag(p[1]) * mag(p[1]) + mag(p[2]) * mag(p[2]);
        len = isqrt(acc);
        if (len != 0) begin
          for (int j = 0; j < 3; j++) begin
            m = ((mag(p[j]) << 16) + len / 2) / len;
            p[j] = p[j] < 0 ? -longint'(m) : longint'(m);
          end
        end
        done = ok;
      end
      best = mag(p[2]);
      cand = mag(p[0]);
      if (cand < best) best = cand;
      cand = mag(rnd16(p[1] * by + p[2] * bz));
      if (cand < best) best = cand;
      root = isqrt(centre_d2(p, d));
      cand = root >= rad ? root - rad : rad - root;
      if (cand < best) best = cand;
      r.found = done;
      r.count = cnt > 2047 ? 11'd2047 : cnt[10:0];
      r.scale = scale[31:0];
      r.fx = p[0][17:0];
      r.fy = p[1][17:0];
      r.fz = p[2][17:0];
      r.mdist = best > 64'hFF_FFFF ? 24'hFF_FFFF : best[23:0];
      return r;
    endfunction

    function void note_point(logic [17:0] x, logic [17:0] y, logic [17:0] z);
      expected_q.push_back(fold(x, y, z));
    endfunction

    function void check_result(fold_res_t a);
      fold_res_t e;
      if (expected_q.size() == 0) begin
        $error("result item with no expectation waiting");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (a.found !== e.found) begin
        $error("found: expected %0d actual %0d", e.found, a.found); errors++;
      end
      if (a.count !== e.count) begin
        $error("reflection_count: expected %0d actual %0d", e.count, a.count); errors++;
      end
      if (a.scale !== e.scale) begin
        $error("orbit_scale: expected %0h actual %0h", e.scale, a.scale); errors++;
      end
      if (a.fx !== e.fx) begin
        $error("folded_x: expected %0h actual %0h", e.fx, a.fx); errors++;
      end
      if (a.fy !== e.fy) begin
        $error("folded_y: expected %0h actual %0h", e.fy, a.fy); errors++;
      end
      if (a.fz !== e.fz) begin
        $error("folded_z: expected %0h actual %0h", e.fz, a.fz); errors++;
      end
      if (a.mdist !== e.mdist) begin
        $error("mirror_distance: expected %0h actual %0h", e.mdist, a.mdist); errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cfdf_in_if  in_ch();
  cfdf_out_if out_ch();

  coxeter_fundamental_domain_fold i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch.sink),
    .out_o   (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fold_scoreboard sb = new();
  int burst_left = 0;
  int hold_req = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int stall_span = 0;

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.point_x = '0; in_ch.point_y = '0; in_ch.point_z = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // receiver: stall pattern plus long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_span = $urandom_range(5, 200);
      end else begin
        stall_span--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_point(in_ch.point_x, in_ch.point_y, in_ch.point_z);
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.found, out_ch.reflection_count, out_ch.orbit_scale,
                         out_ch.folded_x, out_ch.folded_y, out_ch.folded_z,
                         out_ch.mirror_distance});
    end
  end

  task automatic send_point(logic [17:0] x, logic [17:0] y, logic [17:0] z);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.point_x <= x;
    in_ch.point_y <= y;
    in_ch.point_z <= z;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_sphere_point();
    longint x, y, r2, ymax, z;
    x = longint'($urandom_range(0, 131072)) - 65536;
    r2 = 64'd4294967296 - x * x;
    ymax = sb.isqrt(r2);
    y = longint'($urandom_range(0, 2 * ymax)) - ymax;
    z = sb.isqrt(r2 - y * y);
    if ($urandom_range(0, 1)) z = -z;
    send_point(x[17:0], y[17:0], z[17:0]);
  endtask

  task automatic send_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 9) < 8) send_sphere_point();
      else send_point(18'($urandom), 18'($urandom), 18'($urandom));
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(int idx, logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * idx); pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(reg_idx_e'(idx), v);
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [31:0] b_y, logic [31:0] b_z, logic [31:0] c_x,
                           logic [31:0] c_y, logic [31:0] c_z, logic [31:0] c_r);
    write_reg(REG_BY, b_y);
    write_reg(REG_BZ, b_z);
    write_reg(REG_SX, c_x);
    write_reg(REG_SY, c_y);
    write_reg(REG_SZ, c_z);
    write_reg(REG_RAD, c_r);
  endtask

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    // axes, zero-length point, field extremes
    send_point(18'sd65536, '0, '0);
    send_point(-18'sd65536, '0, '0);
    send_point('0, 18'sd65536, '0);
    send_point('0, -18'sd65536, '0);
    send_point('0, '0, 18'sd65536);
    send_point('0, '0, -18'sd65536);
    send_point('0, '0, '0);
    send_point(18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
    send_point(18'h20000, 18'h20000, 18'h20000);
    send_point(18'h20000, 18'h1FFFF, 18'h20000);
    send_point(18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
    send_point(18'sd37837, 18'sd37837, 18'sd37837);
    send_point(-18'sd37837, -18'sd37837, -18'sd37837);
    // long receiver hold-off while the sender keeps offering
    hold_req = 2000;
    send_random(60);
    drain();
    send_random(60);
    // pause until all results are back
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    send_random(40);
    drain();

    // small sphere centred where a point can sit on its centre
    write_all(56756, -32768, 30000, 30000, 10000, 20000);
    write_reg(6, 32'hFFFF_FFFF);
    write_reg(7, 32'h1234_5678);
    send_point(18'sd30000, 18'sd30000, 18'sd10000);
    send_random(30);
    drain();

    // extremes
    write_all(32'h007F_FFFF, 32'h0080_0000, 32'h007F_FFFF, 32'h0080_0000, 0, 32'hFF7F_FFFF);
    send_random(10);
    drain();
    write_all(32'hFF80_0000, 32'h007F_FFFF, 0, 0, 0, 0);
    send_random(10);
    drain();
    write_all(0, 0, 0, 0, 32'h0080_0000, 65536);
    send_random(10);
    drain();

    // random settings around the defaults
    repeat (3) begin
      write_all(56756 + $urandom_range(0, 20000) - 10000,
                -32768 + $urandom_range(0, 20000) - 10000,
                155026 + $urandom_range(0, 40000) - 20000,
                99340 + $urandom_range(0, 40000) - 20000,
                $urandom_range(0, 20000) - 10000,
                172066 + $urandom_range(0, 40000) - 20000);
      send_random(15);
      drain();
    end

    write_all(56756, -32768, 155026, 99340, 0, 172066);
    send_random(30);
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/cfdf_pkg.sv
rtl/cfdf_in_if.sv
rtl/coxeter_fundamental_domain_fold.sv
dv/tb_top.sv
